// File: rtl/pdvcw_pkg.sv
`timescale 1ns / 1ps

package pdvcw_pkg;

  localparam int TERM_BITS    = 12;
  localparam int ARENA_BITS   = 24;
  localparam int POSTING_BITS = 48;
  localparam int VARINT_BYTES = (POSTING_BITS + 6) / 7;
  localparam int CNT_BITS     = $clog2(VARINT_BYTES + 1);

  localparam logic [7:0]  VARINT_MAX     = 8'(VARINT_BYTES);
  localparam logic [7:0]  HEADER_BYTES   = 8'd5;
  localparam logic [7:0]  MAX_PAYLOAD    = 8'd247;
  localparam logic [15:0] CONSUMED_LIMIT = 16'd60000;
  localparam logic [7:0]  CONT_BIT       = 8'd128;
  localparam logic [7:0]  INIT_CHUNK_RST = 8'd16;
  localparam logic [ARENA_BITS:0] ARENA_CAP = {1'b1, {ARENA_BITS{1'b0}}};

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_LINK      = 2'd1,
    KIND_ERR_ORDER = 2'd2,
    KIND_ERR_FULL  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_PLAN,
    S_EMIT,
    S_WB,
    S_FAIL
  } state_e;

  typedef struct packed {
    logic                    valid;
    logic [POSTING_BITS-1:0] last_posting;
    logic [ARENA_BITS-1:0]   chunk_addr;
    logic [7:0]              chunk_size;
    logic [7:0]              write_pos;
    logic [15:0]             consumed;
    logic [31:0]             count;
  } entry_t;

  typedef struct packed {
    logic                 re;
    logic [TERM_BITS-1:0] raddr;
    logic                 we;
    logic [TERM_BITS-1:0] waddr;
    entry_t               wdata;
  } mem_req_t;

  // Payload of a new chunk: a quarter of the bytes consumed so far, raised to
  // the initial size (itself at least one full varint), ORed with 3, capped.
  function automatic logic [7:0] payload_for(logic [15:0] consumed,
                                             logic [7:0] initial_bytes);
    logic [7:0]  floor_size;
    logic [13:0] v;
    floor_size = (initial_bytes < VARINT_MAX) ? VARINT_MAX : initial_bytes;
    v = consumed[15:2];
    if (v < {6'd0, floor_size}) begin
      v = {6'd0, floor_size};
    end
    v = v | 14'd3;
    if (v > {6'd0, MAX_PAYLOAD}) begin
      return MAX_PAYLOAD;
    end
    return v[7:0];
  endfunction

endpackage

// File: rtl/pdvcw_term_mem.sv
`timescale 1ns / 1ps

module pdvcw_term_mem
  import pdvcw_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t term_mem [2**TERM_BITS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      term_mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= term_mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/posting_delta_varint_chunk_writer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// item      in         start & !busy         term_index_i, posting_i
// result    out        result_valid_o        kind_o, address_o, data_o, last_o
// config    in         cfg_we_i              cfg_wdata_i (initial chunk bytes)
//
// An item holds busy high until the sequencer is back in idle, so no new
// item is taken before the last one is through. The sequencer looks up the
// term, plans, emits the varint bytes (1 to 7), after a link if a new chunk
// is opened, and writes the entry back. A non-increasing posting fails after
// the lookup; arena-full fails after it on a term's first chunk and after
// planning otherwise. One arena write issues per cycle around one term table
// read-modify-write. After reset the term table is swept clean, busy high.
// Results cannot be stalled; each is shown for exactly one cycle.

module posting_delta_varint_chunk_writer_core
  import pdvcw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [TERM_BITS-1:0]    term_index_i,
  input  logic [POSTING_BITS-1:0] posting_i,
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_wdata_i,
  output logic                    result_valid_o,
  output logic [1:0]              kind_o,
  output logic [ARENA_BITS-1:0]   address_o,
  output logic [31:0]             data_o,
  output logic                    last_o
);

  state_e                  state_q, state_d;
  logic [7:0]              icb_q;
  logic [ARENA_BITS:0]     fp_q, fp_d;
  logic [TERM_BITS-1:0]    term_q, term_d;
  logic [TERM_BITS-1:0]    clr_q, clr_d;
  logic [POSTING_BITS-1:0] posting_q, posting_d;
  logic [POSTING_BITS-1:0] delta_q, delta_d;
  logic [31:0]             cnt_q, cnt_d;
  logic [ARENA_BITS-1:0]   chunk_q, chunk_d;
  logic [7:0]              csize_q, csize_d;
  logic [7:0]              pos_q, pos_d;
  logic [15:0]             cons_q, cons_d;
  logic [ARENA_BITS:0]     fpw_q, fpw_d;
  logic [7:0]              pay_q, pay_d;
  logic [CNT_BITS-1:0]     rem_q, rem_d;
  kind_e                   fail_q, fail_d;

  logic                    ovalid_q, ovalid_d;
  kind_e                   okind_q, okind_d;
  logic [ARENA_BITS-1:0]   oaddr_q, oaddr_d;
  logic [31:0]             odata_q, odata_d;
  logic                    olast_q, olast_d;

  mem_req_t                mem_req;
  entry_t                  rd_entry;

  logic                    accept;
  logic [POSTING_BITS:0]   diff;
  logic [POSTING_BITS-1:0] prev;
  logic [7:0]              pay0, pay2, pos_c, room;
  logic [ARENA_BITS:0]     alloc0_end, alloc2_end;
  logic [CNT_BITS-1:0]     nbytes;

  pdvcw_term_mem u_term_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_entry)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    nbytes = CNT_BITS'(1);
    for (int g = 1; g < VARINT_BYTES; g++) begin
      if ((delta_q >> (7 * g)) != '0) begin
        nbytes = CNT_BITS'(g + 1);
      end
    end
  end

  always_comb begin
    prev       = rd_entry.valid ? rd_entry.last_posting : '0;
    diff       = {1'b0, posting_q} - {1'b0, prev};
    pay0       = payload_for(16'd0, icb_q);
    alloc0_end = fp_q + (ARENA_BITS+1)'(pay0) + (ARENA_BITS+1)'(HEADER_BYTES);
    pos_c      = (pos_q > csize_q) ? csize_q : pos_q;
    room       = csize_q - pos_c;
    pay2       = payload_for(cons_q, icb_q);
    alloc2_end = fpw_q + (ARENA_BITS+1)'(pay2) + (ARENA_BITS+1)'(HEADER_BYTES);
  end

  always_comb begin
    state_d   = state_q;
    fp_d      = fp_q;
    term_d    = term_q;
    clr_d     = clr_q;
    posting_d = posting_q;
    delta_d   = delta_q;
    cnt_d     = cnt_q;
    chunk_d   = chunk_q;
    csize_d   = csize_q;
    pos_d     = pos_q;
    cons_d    = cons_q;
    fpw_d     = fpw_q;
    pay_d     = pay_q;
    rem_d     = rem_q;
    fail_d    = fail_q;
    ovalid_d  = 1'b0;
    okind_d   = KIND_DATA;
    oaddr_d   = '0;
    odata_d   = '0;
    olast_d   = 1'b0;
    mem_req   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
        clr_d         = clr_q + TERM_BITS'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = term_index_i;
          term_d        = term_index_i;
          posting_d     = posting_i;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        delta_d = diff[POSTING_BITS-1:0];
        cnt_d   = rd_entry.valid ? rd_entry.count + 32'd1 : 32'd1;
        if (rd_entry.valid) begin
          chunk_d = rd_entry.chunk_addr;
          csize_d = rd_entry.chunk_size;
          pos_d   = rd_entry.write_pos;
          cons_d  = rd_entry.consumed;
          fpw_d   = fp_q;
        end else begin
          chunk_d = fp_q[ARENA_BITS-1:0];
          csize_d = pay0 + HEADER_BYTES;
          pos_d   = HEADER_BYTES;
          cons_d  = 16'(pay0);
          fpw_d   = alloc0_end;
        end
        priority if (diff[POSTING_BITS] || (diff == '0)) begin
          fail_d  = KIND_ERR_ORDER;
          state_d = S_FAIL;
        end else if (!rd_entry.valid && (alloc0_end > ARENA_CAP)) begin
          fail_d  = KIND_ERR_FULL;
          state_d = S_FAIL;
        end else begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        pos_d = pos_c;
        pay_d = pay2;
        rem_d = nbytes;
        // The arena check covers the chunk that this item may have to open.
        if ((8'(nbytes) > room) && (alloc2_end > ARENA_CAP)) begin
          fail_d  = KIND_ERR_FULL;
          state_d = S_FAIL;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        ovalid_d = 1'b1;
        if (pos_q >= csize_q) begin
          okind_d = KIND_LINK;
          oaddr_d = chunk_q;
          odata_d = 32'(fpw_q[ARENA_BITS-1:0]);
          chunk_d = fpw_q[ARENA_BITS-1:0];
          fpw_d   = fpw_q + (ARENA_BITS+1)'(pay_q) + (ARENA_BITS+1)'(HEADER_BYTES);
          csize_d = pay_q + HEADER_BYTES;
          pos_d   = HEADER_BYTES;
          if (cons_q < CONSUMED_LIMIT) begin
            cons_d = cons_q + 16'(pay_q);
          end
        end else begin
          okind_d = KIND_DATA;
          oaddr_d = chunk_q + ARENA_BITS'(pos_q);
          odata_d = 32'((rem_q != CNT_BITS'(1)) ? (CONT_BIT | {1'b0, delta_q[6:0]})
                                                 : {1'b0, delta_q[6:0]});
          delta_d = delta_q >> 7;
          pos_d   = pos_q + 8'd1;
          rem_d   = rem_q - CNT_BITS'(1);
          if (rem_q == CNT_BITS'(1)) begin
            olast_d = 1'b1;
            state_d = S_WB;
          end
        end
      end
      S_WB: begin
        // The next item is read only after this write lands, so the table
        // never needs forwarding.
        mem_req.we                 = 1'b1;
        mem_req.waddr              = term_q;
        mem_req.wdata.valid        = 1'b1;
        mem_req.wdata.last_posting = posting_q;
        mem_req.wdata.chunk_addr   = chunk_q;
        mem_req.wdata.chunk_size   = csize_q;
        mem_req.wdata.write_pos    = pos_q;
        mem_req.wdata.consumed     = cons_q;
        mem_req.wdata.count        = cnt_q;
        fp_d                       = fpw_q;
        state_d                    = S_IDLE;
      end
      S_FAIL: begin
        ovalid_d = 1'b1;
        okind_d  = fail_q;
        olast_d  = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      fp_q     <= '0;
      icb_q    <= INIT_CHUNK_RST;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      fp_q     <= fp_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        icb_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    term_q    <= term_d;
    posting_q <= posting_d;
    delta_q   <= delta_d;
    cnt_q     <= cnt_d;
    chunk_q   <= chunk_d;
    csize_q   <= csize_d;
    pos_q     <= pos_d;
    cons_q    <= cons_d;
    fpw_q     <= fpw_d;
    pay_q     <= pay_d;
    rem_q     <= rem_d;
    fail_q    <= fail_d;
    okind_q   <= okind_d;
    oaddr_q   <= oaddr_d;
    odata_q   <= odata_d;
    olast_q   <= olast_d;
  end

  assign result_valid_o = ovalid_q;
  assign kind_o         = okind_q;
  assign address_o      = oaddr_q;
  assign data_o         = odata_q;
  assign last_o         = olast_q;

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == S_EMIT || $past(state_q) == S_FAIL))
    else $error("result shown outside an emitting state");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == KIND_ERR_ORDER || kind_o == KIND_ERR_FULL))
    |-> (last_o && address_o == '0 && data_o == '0))
    else $error("error result is not a lone zero item");

  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == S_CLEAR || state_q == S_WB))
    else $error("term table written outside clear or write-back");

  a_pos_in_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (pos_q <= csize_q))
    else $error("write position beyond chunk end");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOKUP))
    else $error("accepted item did not start a table lookup");

endmodule
